// ----- hdl/vmnn_pkg.sv -----
// Shared types and constants of the voxel map nearest-neighbour block.
`timescale 1ns / 1ps
package vmnn_pkg;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef struct packed {
    logic [31:0] tag;
    coord_t      z;
    coord_t      y;
    coord_t      x;
  } pt_t;

  localparam int KEY_W = 24;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_PRUNE  = 2'd2;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_CELL_FULL  = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;

  localparam logic [1:0] REG_EDGE  = 2'd0;
  localparam logic [1:0] REG_CPL   = 2'd1;
  localparam logic [1:0] REG_RANGE = 2'd2;
  localparam logic [1:0] REG_MATCH = 2'd3;

  localparam logic [30:0] EDGE_MIN    = 31'd655;
  localparam logic [30:0] EDGE_RST    = 31'd65536;
  localparam logic [5:0]  CPL_RST     = 6'd20;
  localparam logic [30:0] RANGE_RST   = 31'd6553600;
  localparam logic [30:0] MATCH_RST   = 31'd65536;

endpackage

// ----- hdl/vmnn_div.sv -----
// Iterative restoring divider giving the truncated cell key of one coordinate.
`timescale 1ns / 1ps
module vmnn_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  vmnn_pkg::coord_t             dividend,
  input  logic [30:0]                  divisor,
  output vmnn_pkg::unit_sts_t          sts,
  output logic [vmnn_pkg::KEY_W-1:0]   key
);
  import vmnn_pkg::*;

  logic [30:0]      rem_r;
  logic [31:0]      quo_r;
  logic [30:0]      dvs_r;
  logic [4:0]       cnt_r;
  logic             neg_r;
  logic             busy_r;
  logic             done_r;
  logic [KEY_W-1:0] key_r;

  logic [31:0] trial;
  logic        ge;
  logic [30:0] rem_c;
  logic [31:0] quo_c;
  logic [31:0] quo_neg;

  always_comb begin
    trial   = {rem_r, quo_r[31]};
    ge      = trial >= {1'b0, dvs_r};
    rem_c   = ge ? 31'(trial - {1'b0, dvs_r}) : trial[30:0];
    quo_c   = {quo_r[30:0], ge};
    quo_neg = ~quo_c + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend[31] ? (~dividend + 32'd1) : dividend;
      neg_r <= dividend[31];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_c;
      quo_r <= quo_c;
      if (cnt_r == 5'd31) begin
        key_r <= neg_r ? quo_neg[KEY_W-1:0] : quo_c[KEY_W-1:0];
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign key      = key_r;

endmodule

// ----- hdl/vmnn_sqdist.sv -----
// Shared squared-distance unit: one multiplier stepped over three axes, saturating sum.
`timescale 1ns / 1ps
module vmnn_sqdist (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  vmnn_pkg::coord_t    pa_x,
  input  vmnn_pkg::coord_t    pa_y,
  input  vmnn_pkg::coord_t    pa_z,
  input  vmnn_pkg::coord_t    pb_x,
  input  vmnn_pkg::coord_t    pb_y,
  input  vmnn_pkg::coord_t    pb_z,
  output vmnn_pkg::unit_sts_t sts,
  output logic [63:0]         sq_dist
);
  import vmnn_pkg::*;

  coord_t [2:0] a_r;
  coord_t [2:0] b_r;
  logic [1:0]   ax_r;
  logic [1:0]   ph_r;
  logic [31:0]  mag_r;
  logic [63:0]  prod_r;
  logic [63:0]  acc_r;
  logic         busy_r;
  logic         done_r;

  logic signed [32:0] diff;
  logic [32:0]        diff_neg;
  logic [31:0]        mag_c;
  logic [64:0]        sum;

  always_comb begin
    diff     = {a_r[ax_r][31], a_r[ax_r]} - {b_r[ax_r][31], b_r[ax_r]};
    diff_neg = 33'(-diff);
    mag_c    = diff[32] ? diff_neg[31:0] : diff[31:0];
    sum      = {1'b0, acc_r} + {1'b0, prod_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ax_r   <= '0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ax_r   <= '0;
        ph_r   <= '0;
      end else if (busy_r) begin
        if (ph_r == 2'd2) begin
          ph_r <= '0;
          if (ax_r == 2'd2) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            ax_r <= ax_r + 2'd1;
          end
        end else begin
          ph_r <= ph_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= {pa_z, pa_y, pa_x};
      b_r   <= {pb_z, pb_y, pb_x};
      acc_r <= '0;
    end else if (busy_r) begin
      case (ph_r)
        2'd0:    mag_r  <= mag_c;
        2'd1:    prod_r <= mag_r * mag_r;
        2'd2:    acc_r  <= sum[64] ? '1 : sum[63:0];
        default: mag_r  <= mag_r;
      endcase
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sq_dist  = acc_r;

endmodule

// ----- hdl/voxel_map_nearest_neighbor.sv -----
// Voxel map top level: cell table, point store and the operation sequencer.
// Usage:
//   in_*  : one operation per transfer; in_tuser carries the opcode (insert,
//           query, prune), in_tdata the point or origin and its tag.
//   out_* : exactly one result per operation, in order.
//   cfg_* : register writes (voxel edge, cell limit, range and match limits),
//           taken at any time; write them only while the block is idle.
// Operation steps, with N = CELL_CAPACITY:
//   insert : key division of the three axes, then a table scan of up to N rows.
//   query  : key division and limit squaring, then 27 scans, one per
//            neighbour cell, of up to N rows each, plus a distance per point examined.
//   prune  : limit squaring, then a scan of N rows plus a distance check per valid cell.
//   The table scan reads one row per cycle, pausing while a prune checks a cell and
//   stopping at a key hit; one operation is in work at a time.
// After reset the cell table is cleared row by row; in_tready stays low
// meanwhile, cfg writes are taken throughout.
// A finished result waits in the output register while the next operation
// is accepted; if the receiver stalls, the block holds its next result
// until the output register is free.
`timescale 1ns / 1ps
module voxel_map_nearest_neighbor #(
  parameter int CELL_CAPACITY   = 4096,
  parameter int POINTS_PER_CELL = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // opcode
  input  logic [127:0] in_tdata,   // pos_x, pos_y, pos_z, point_tag
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // status, matched, near_x, near_y, near_z, near_tag,
                                   // cells_removed
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import vmnn_pkg::*;

  localparam int CAP = CELL_CAPACITY;
  localparam int PPC = POINTS_PER_CELL;
  localparam int CW  = $clog2(CAP);
  localparam int FW  = $clog2(PPC + 1);
  localparam int PAW = $clog2(CAP * PPC);
  localparam logic [CW:0] SIDX_END  = (CW+1)'(CAP);
  localparam logic [CW:0] SIDX_LAST = (CW+1)'(CAP - 1);

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] kx;
    logic [KEY_W-1:0] ky;
    logic [KEY_W-1:0] kz;
    logic [FW-1:0]    fill;
  } row_t;

  typedef enum logic [16:0] {
    S_CLR  = 17'h00001,
    S_IDLE = 17'h00002,
    S_DIVGO= 17'h00004,
    S_DIVW = 17'h00008,
    S_LIMGO= 17'h00010,
    S_LIMW = 17'h00020,
    S_NBR  = 17'h00040,
    S_SCAN = 17'h00080,
    S_INS  = 17'h00100,
    S_QRD  = 17'h00200,
    S_QST  = 17'h00400,
    S_QW   = 17'h00800,
    S_PRD  = 17'h01000,
    S_PST  = 17'h02000,
    S_PW   = 17'h04000,
    S_FIN  = 17'h08000,
    S_OUT  = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  logic [30:0] edge_r, range_r, match_r;
  logic [5:0]  cpl_r;

  logic [1:0]             op_r, op_nxt;
  coord_t [2:0]           pos_r, pos_nxt;
  logic [31:0]            tag_r, tag_nxt;
  logic [2:0][KEY_W-1:0]  key_r, key_nxt;
  logic [1:0]             ax_r, ax_nxt;
  logic [2:0][1:0]        off_r, off_nxt;
  logic [CW:0]            sidx_r, sidx_nxt;
  logic [CW-1:0]          didx_r, didx_nxt;
  logic                   pend_r, pend_nxt;
  row_t                   row_r, row_nxt;
  logic                   hit_r, hit_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [CW-1:0]          free_slot_r, free_slot_nxt;
  logic [FW-1:0]          n_r, n_nxt;
  logic                   found_r, found_nxt;
  logic [63:0]            bestd_r, bestd_nxt;
  pt_t                    best_r, best_nxt;
  logic [63:0]            lim2_r, lim2_nxt;
  logic [12:0]            removed_r, removed_nxt;
  logic [1:0]             status_r, status_nxt;
  logic                   matched_r, matched_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [143:0]           out_data_r, out_data_nxt;

  row_t          tbl_mem [0:CAP-1];
  row_t          tbl_q;
  logic          tbl_we;
  logic [CW-1:0] tbl_wa, tbl_ra;
  row_t          tbl_wd;

  pt_t           pt_mem [0:CAP*PPC-1];
  pt_t           pt_q;
  logic          pt_we, pt_re;
  logic [PAW-1:0] pt_wa, pt_ra;
  pt_t           pt_wd;

  logic             div_start;
  unit_sts_t        div_sts;
  logic [KEY_W-1:0] div_key;
  logic [30:0]      edge_eff;

  logic        dist_start;
  unit_sts_t   dist_sts;
  logic [63:0] sq_dist;
  coord_t      pa_x, pa_y, pa_z, pb_x, pb_y, pb_z;

  logic [2:0][KEY_W-1:0] skey;
  logic [2:0][1:0]       off_inc;
  logic                  nbr_last;
  logic                  key_hit;
  logic                  issue;
  logic [FW-1:0]         lim;
  logic [CW-1:0]         ins_slot;
  logic [PAW-1:0]        ins_addr;
  logic [PAW-1:0]        cur_base;
  logic [30:0]           lim_sel;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_q <= tbl_mem[tbl_ra];
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= pt_wd;
    end
    if (pt_re) begin
      pt_q <= pt_mem[pt_ra];
    end
  end

  assign edge_eff = (edge_r < EDGE_MIN) ? EDGE_MIN : edge_r;

  vmnn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pos_r[ax_r]),
    .divisor  (edge_eff),
    .sts      (div_sts),
    .key      (div_key)
  );

  vmnn_sqdist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dist_start),
    .pa_x    (pa_x),
    .pa_y    (pa_y),
    .pa_z    (pa_z),
    .pb_x    (pb_x),
    .pb_y    (pb_y),
    .pb_z    (pb_z),
    .sts     (dist_sts),
    .sq_dist (sq_dist)
  );

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      skey[a] = key_r[a] + KEY_W'(off_r[a]) - KEY_W'(1);
    end
    key_hit = tbl_q.vld && (tbl_q.kx == skey[0]) && (tbl_q.ky == skey[1]) &&
              (tbl_q.kz == skey[2]);
    nbr_last = (off_r[0] == 2'd2) && (off_r[1] == 2'd2) && (off_r[2] == 2'd2);
    off_inc  = off_r;
    if (off_r[2] != 2'd2) begin
      off_inc[2] = off_r[2] + 2'd1;
    end else begin
      off_inc[2] = 2'd0;
      if (off_r[1] != 2'd2) begin
        off_inc[1] = off_r[1] + 2'd1;
      end else begin
        off_inc[1] = 2'd0;
        off_inc[0] = off_r[0] + 2'd1;
      end
    end
    issue    = sidx_r < SIDX_END;
    lim      = (PPC < 32'(cpl_r)) ? FW'(PPC) : FW'(cpl_r);
    ins_slot = hit_r ? didx_r : free_slot_r;
    ins_addr = PAW'(ins_slot) * PAW'(PPC) + (hit_r ? PAW'(row_r.fill) : PAW'(0));
    cur_base = PAW'(didx_r) * PAW'(PPC);
    lim_sel  = (op_r == OP_QUERY) ? match_r : range_r;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    tag_nxt        = tag_r;
    key_nxt        = key_r;
    ax_nxt         = ax_r;
    off_nxt        = off_r;
    sidx_nxt       = sidx_r;
    didx_nxt       = didx_r;
    pend_nxt       = pend_r;
    row_nxt        = row_r;
    hit_nxt        = hit_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    n_nxt          = n_r;
    found_nxt      = found_r;
    bestd_nxt      = bestd_r;
    best_nxt       = best_r;
    lim2_nxt       = lim2_r;
    removed_nxt    = removed_r;
    status_nxt     = status_r;
    matched_nxt    = matched_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;

    tbl_we     = 1'b0;
    tbl_wa     = didx_r;
    tbl_wd     = row_r;
    tbl_ra     = sidx_r[CW-1:0];
    pt_we      = 1'b0;
    pt_wa      = ins_addr;
    pt_wd      = {tag_r, pos_r[2], pos_r[1], pos_r[0]};
    pt_re      = 1'b0;
    pt_ra      = cur_base + PAW'(n_r);
    div_start  = 1'b0;
    dist_start = 1'b0;
    pa_x       = pt_q.x;
    pa_y       = pt_q.y;
    pa_z       = pt_q.z;
    pb_x       = pos_r[0];
    pb_y       = pos_r[1];
    pb_z       = pos_r[2];

    case (state_r)
      S_CLR: begin
        tbl_we = 1'b1;
        tbl_wa = sidx_r[CW-1:0];
        tbl_wd = '0;
        if (sidx_r == SIDX_LAST) begin
          sidx_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          sidx_nxt = sidx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt         = in_tuser;
          pos_nxt        = {in_tdata[95:64], in_tdata[63:32], in_tdata[31:0]};
          tag_nxt        = in_tdata[127:96];
          ax_nxt         = '0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          found_nxt      = 1'b0;
          best_nxt       = '0;
          removed_nxt    = '0;
          status_nxt     = ST_DONE;
          case (in_tuser)
            OP_INSERT: state_nxt = S_DIVGO;
            OP_QUERY:  state_nxt = S_DIVGO;
            OP_PRUNE:  state_nxt = S_LIMGO;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_DIVGO: begin
        div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_sts.done) begin
          key_nxt[ax_r] = div_key;
          if (ax_r == 2'd2) begin
            if (op_r == OP_QUERY) begin
              state_nxt = S_LIMGO;
            end else begin
              off_nxt   = {2'd1, 2'd1, 2'd1};
              state_nxt = S_NBR;
            end
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = S_DIVGO;
          end
        end
      end
      S_LIMGO: begin
        dist_start = 1'b1;
        pa_x       = coord_t'({1'b0, lim_sel});
        pa_y       = '0;
        pa_z       = '0;
        pb_x       = '0;
        pb_y       = '0;
        pb_z       = '0;
        state_nxt  = S_LIMW;
      end
      S_LIMW: begin
        if (dist_sts.done) begin
          lim2_nxt = sq_dist;
          sidx_nxt = '0;
          pend_nxt = 1'b0;
          if (op_r == OP_QUERY) begin
            off_nxt   = '0;
            state_nxt = S_NBR;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_NBR: begin
        sidx_nxt  = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        sidx_nxt = sidx_r + (CW+1)'(issue);
        pend_nxt = issue;
        didx_nxt = sidx_r[CW-1:0];
        if (pend_r && op_r == OP_PRUNE && tbl_q.vld) begin
          row_nxt   = tbl_q;
          didx_nxt  = didx_r;
          state_nxt = S_PRD;
        end else if (pend_r && op_r != OP_PRUNE && key_hit) begin
          row_nxt  = tbl_q;
          didx_nxt = didx_r;
          hit_nxt  = 1'b1;
          n_nxt    = '0;
          state_nxt = (op_r == OP_INSERT) ? S_INS : S_QRD;
        end else begin
          if (pend_r && op_r == OP_INSERT && !tbl_q.vld && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = didx_r;
          end
          if (!pend_r && !issue) begin
            case (op_r)
              OP_INSERT: state_nxt = S_INS;
              OP_QUERY: begin
                if (nbr_last) begin
                  state_nxt = S_FIN;
                end else begin
                  off_nxt   = off_inc;
                  state_nxt = S_NBR;
                end
              end
              default:   state_nxt = S_FIN;
            endcase
          end
        end
      end
      S_INS: begin
        tbl_wa = ins_slot;
        if (hit_r) begin
          if (row_r.fill < lim) begin
            pt_we       = 1'b1;
            tbl_we      = 1'b1;
            tbl_wd      = row_r;
            tbl_wd.fill = row_r.fill + 1'b1;
          end else begin
            status_nxt = ST_CELL_FULL;
          end
        end else if (free_found_r) begin
          pt_we  = 1'b1;
          tbl_we = 1'b1;
          tbl_wd = {1'b1, key_r[0], key_r[1], key_r[2], FW'(1)};
        end else begin
          status_nxt = ST_TABLE_FULL;
        end
        state_nxt = S_FIN;
      end
      S_QRD: begin
        if (n_r < row_r.fill) begin
          pt_re     = 1'b1;
          state_nxt = S_QST;
        end else if (nbr_last) begin
          state_nxt = S_FIN;
        end else begin
          off_nxt   = off_inc;
          state_nxt = S_NBR;
        end
      end
      S_QST: begin
        dist_start = 1'b1;
        state_nxt  = S_QW;
      end
      S_QW: begin
        if (dist_sts.done) begin
          if (!found_r || sq_dist < bestd_r) begin
            found_nxt = 1'b1;
            bestd_nxt = sq_dist;
            best_nxt  = pt_q;
          end
          n_nxt     = n_r + 1'b1;
          state_nxt = S_QRD;
        end
      end
      S_PRD: begin
        pt_re     = 1'b1;
        pt_ra     = cur_base;
        state_nxt = S_PST;
      end
      S_PST: begin
        dist_start = 1'b1;
        state_nxt  = S_PW;
      end
      S_PW: begin
        if (dist_sts.done) begin
          if (sq_dist > lim2_r) begin
            tbl_we      = 1'b1;
            tbl_wd      = row_r;
            tbl_wd.vld  = 1'b0;
            removed_nxt = removed_r + 13'd1;
          end
          sidx_nxt  = (CW+1)'(didx_r) + 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_FIN: begin
        matched_nxt = found_r && (bestd_r < lim2_r);
        if (!(found_r && (bestd_r < lim2_r))) begin
          best_nxt = '0;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {removed_r, best_r, matched_r, status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      sidx_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      edge_r      <= EDGE_RST;
      cpl_r       <= CPL_RST;
      range_r     <= RANGE_RST;
      match_r     <= MATCH_RST;
    end else begin
      state_r     <= state_nxt;
      sidx_r      <= sidx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_EDGE:  edge_r  <= cfg_data[30:0];
          REG_CPL:   cpl_r   <= cfg_data[5:0];
          REG_RANGE: range_r <= cfg_data[30:0];
          REG_MATCH: match_r <= cfg_data[30:0];
          default:   edge_r  <= edge_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    tag_r        <= tag_nxt;
    key_r        <= key_nxt;
    ax_r         <= ax_nxt;
    off_r        <= off_nxt;
    didx_r       <= didx_nxt;
    row_r        <= row_nxt;
    hit_r        <= hit_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    n_r          <= n_nxt;
    found_r      <= found_nxt;
    bestd_r      <= bestd_nxt;
    best_r       <= best_nxt;
    lim2_r       <= lim2_nxt;
    removed_r    <= removed_nxt;
    status_r     <= status_nxt;
    matched_r    <= matched_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  a_clr_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_tready)
    else $error("input taken during table clear");

  a_dist_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dist_start |-> !dist_sts.busy)
    else $error("distance unit restarted while busy");

  a_drop_no_removal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] != ST_DONE) |-> (out_tdata[143:131] == 13'd0))
    else $error("dropped insert reports removed cells");

endmodule
